/* src/websocket_frame_deframer_macros.svh */
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTHESIS
`define WSFD_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("wsfd assertion failed");
`define WSFD_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("wsfd assertion failed");
`else
`define WSFD_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define WSFD_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

/* src/wsfd_pkg.sv */
// shared types and constants of the websocket frame deframer
`default_nettype none
package wsfd_pkg;
	localparam int unsigned ByteW = 8;
	localparam int unsigned OpW   = 4;
	localparam int unsigned LenW  = 64;
	localparam int unsigned KeyW  = 32;
	localparam int unsigned UserW = 8;

	// 7-bit length codes that announce an extended length
	localparam logic [6:0] LEN_CODE16 = 7'd126;
	localparam logic [6:0] LEN_CODE64 = 7'd127;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
	} in_item_t;

	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] payload_byte;
		logic             byte_valid;
		logic [OpW-1:0]   frame_opcode;
		logic             frame_end;
	} result_t;
endpackage
`default_nettype wire

/* src/wsfd_in_stage.sv */
// input register stage of the websocket frame deframer
`default_nettype none
module wsfd_in_stage import wsfd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [ByteW-1:0] in_data,
	input  wire logic             advance,
	output logic                  in_ready,
	output in_item_t              item
);
	logic             valid_s1;
	logic [ByteW-1:0] data_s1;

	// stage frees up when its item moves on
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	assign item.valid = valid_s1;
	assign item.data  = data_s1;
endmodule
`default_nettype wire

/* src/wsfd_parser.sv */
// frame header parser, length counter and payload unmasking
`default_nettype none
module wsfd_parser import wsfd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_item_t item,
	input  wire logic     step,
	output result_t       res
);
	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	logic [2:0]      phase_q,  phase_d;
	logic [LenW-1:0] len_q,    len_d;
	logic [2:0]      cnt_q,    cnt_d;
	logic [KeyW-1:0] key_q,    key_d;
	logic [1:0]      idx_q,    idx_d;
	logic [OpW-1:0]  op_q,     op_d;
	logic            masked_q, masked_d;

	logic [ByteW-1:0] b;
	logic [ByteW-1:0] key_byte;
	logic [LenW-1:0]  len_ext;
	logic [LenW-1:0]  len_dec;

	assign b       = item.data;
	assign len_ext = {len_q[LenW-ByteW-1:0], b};
	assign len_dec = len_q - LenW'(1);

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		key_d    = key_q;
		idx_d    = idx_q;
		op_d     = op_q;
		masked_d = masked_q;
		res      = '0;
		res.frame_opcode = op_q;
		case (phase_q)
			PH_HDR1: begin
				masked_d = b[7];
				if (b[6:0] == LEN_CODE16) begin
					phase_d = PH_EXTLEN;
					cnt_d   = 3'd1;
					len_d   = '0;
				end else if (b[6:0] == LEN_CODE64) begin
					phase_d = PH_EXTLEN;
					cnt_d   = 3'd7;
					len_d   = '0;
				end else begin
					len_d = LenW'(b[6:0]);
					if (b[7]) begin
						phase_d = PH_KEY;
						cnt_d   = 3'd3;
					end else if (b[6:0] == 7'd0) begin
						phase_d       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_EXTLEN: begin
				len_d = len_ext;
				if (cnt_q == 3'd0) begin
					if (masked_q) begin
						phase_d = PH_KEY;
						cnt_d   = 3'd3;
					end else if (len_ext == '0) begin
						phase_d       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[KeyW-ByteW-1:0], b};
				if (cnt_q == 3'd0) begin
					if (len_q == '0) begin
						phase_d       = PH_HDR0;
						res.valid     = 1'b1;
						res.frame_end = 1'b1;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			PH_PAYLOAD: begin
				res.valid        = 1'b1;
				res.byte_valid   = 1'b1;
				res.payload_byte = masked_q ? (b ^ key_byte) : b;
				idx_d            = idx_q + 2'd1;
				len_d            = len_dec;
				if (len_dec == '0) begin
					res.frame_end = 1'b1;
					phase_d       = PH_HDR0;
				end
			end
			default: begin
				// first header byte; unused codes land here too
				op_d     = b[3:0];
				phase_d  = PH_HDR1;
				len_d    = '0;
				cnt_d    = '0;
				key_d    = '0;
				idx_d    = '0;
				masked_d = 1'b0;
			end
		endcase
		if (!item.valid) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			len_q    <= '0;
			cnt_q    <= '0;
			key_q    <= '0;
			idx_q    <= '0;
			op_q     <= '0;
			masked_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			key_q    <= key_d;
			idx_q    <= idx_d;
			op_q     <= op_d;
			masked_q <= masked_d;
		end
	end
endmodule
`default_nettype wire

/* src/websocket_frame_deframer.sv */
// websocket frame deframer: input register, header parser, result register
// a byte passes the input register; its result is then offered from the result register
// throughput: one byte per cycle, set by the single parse step between the two registers
// a stalled result register holds the input register, which then drops s_axis_tready
// reset: arst_n clears both valid flags and the parser to await the first header byte
`default_nettype none
`include "websocket_frame_deframer_macros.svh"
module websocket_frame_deframer import wsfd_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [ByteW-1:0] s_axis_tdata,   // [7:0] in_byte
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [ByteW-1:0]      m_axis_tdata,   // [7:0] payload_byte
	output logic                  m_axis_tlast,   // frame_end
	output logic [UserW-1:0]      m_axis_tuser    // [0] byte_valid, [4:1] frame_opcode, [7:5] zero
);
	in_item_t item;
	result_t  res;
	logic     advance;
	logic     step;

	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             out_bvalid_q;
	logic [OpW-1:0]   out_op_q;
	logic             out_end_q;

	// the input register moves on whenever the result register is free or being drained
	assign advance = !out_valid_q || m_axis_tready;
	assign step    = item.valid && advance;

	wsfd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_data  (s_axis_tdata),
		.advance  (advance),
		.in_ready (s_axis_tready),
		.item     (item)
	);

	wsfd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.step   (step),
		.res    (res)
	);

	// result register; header bytes that make no result leave it empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_byte_q   <= res.payload_byte;
			out_bvalid_q <= res.byte_valid;
			out_op_q     <= res.frame_opcode;
			out_end_q    <= res.frame_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tuser  = {3'b000, out_op_q, out_bvalid_q};

	// an empty result only ever closes a frame
	`WSFD_ASSERT_IMP(a_empty_is_end, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
	// an empty result carries a zero byte
	`WSFD_ASSERT_IMP(a_empty_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
	// backpressure at the input only comes from a held item
	`WSFD_ASSERT_IMP(a_ready_low, clk, arst_n, !s_axis_tready, item.valid && !advance)
	// an accepted byte always sits in the input register next cycle
	`WSFD_ASSERT_NXT(a_accept_lands, clk, arst_n, s_axis_tvalid && s_axis_tready, item.valid)
endmodule
`default_nettype wire
